@@ sv/corated_cosine_similarity_unit_assert.svh @@
// Assertion macros for the co-rated cosine similarity unit.
// Used by the port checker; no other dependencies.
`ifndef CORATED_COSINE_SIMILARITY_UNIT_ASSERT_SVH
`define CORATED_COSINE_SIMILARITY_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CCS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccs assertion failed");

// Next-cycle implication.
`define CCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccs assertion failed");

`endif

@@ sv/ccs_pkg.sv @@
// Shared types and constants for the co-rated cosine similarity unit.
// No dependencies.
`timescale 1ns / 1ps

package ccs_pkg;

  localparam int RATING_W    = 4;   // field width of each rating
  localparam int RATING_BITS = 4;   // rating bits actually used
  localparam logic [RATING_W-1:0] RATING_MASK = RATING_W'((1 << RATING_BITS) - 1);

  localparam int COUNT_W = 14;
  localparam int SUM_W   = 21;
  localparam int SIM_W   = 16;
  localparam int FRAC_W  = 15;
  localparam int PROD_W  = 2 * SUM_W;
  localparam int ROOT_W  = SUM_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [SIM_W-1:0]   Q_ONE     = SIM_W'(1 << FRAC_W);

  localparam int IN_DATA_W  = 8;    // two ratings, padded to bytes
  localparam int OUT_DATA_W = 32;   // similarity + count, padded to bytes

  localparam int QUEUE_DEPTH = 2;

  // Finished accumulation of one vector pair.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   dot;
    logic [SUM_W-1:0]   sq_a;
    logic [SUM_W-1:0]   sq_b;
  } job_t;

endpackage

@@ sv/ccs_front.sv @@
// Front end: takes rating transactions, accumulates co-rated sums, hands a job on.
// Depends on ccs_pkg.
`timescale 1ns / 1ps

module ccs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ccs_pkg::IN_DATA_W-1:0] s_tdata,   // rating_a, rating_b
  input  logic                          s_tlast,   // last_user
  input  logic                          q_full,
  output logic                          push,
  output ccs_pkg::job_t                 push_job
);

  localparam int RW = ccs_pkg::RATING_W;
  localparam int SW = ccs_pkg::SUM_W;
  localparam int CW = ccs_pkg::COUNT_W;

  logic [CW-1:0] pair_count;
  logic [SW-1:0] dot_sum, square_sum_a, square_sum_b;

  logic [RW-1:0]   ra, rb;
  logic            both;
  logic [2*RW-1:0] p_ab, p_aa, p_bb;
  logic [CW:0]     cnt_w;
  logic [SW:0]     dot_w, sqa_w, sqb_w;
  logic            accept;
  ccs_pkg::job_t   upd;

  assign ra   = s_tdata[RW-1:0] & ccs_pkg::RATING_MASK;
  assign rb   = s_tdata[2*RW-1:RW] & ccs_pkg::RATING_MASK;
  assign both = (ra != '0) && (rb != '0);
  assign p_ab = ra * rb;
  assign p_aa = ra * ra;
  assign p_bb = rb * rb;

  assign cnt_w = {1'b0, pair_count} + (CW+1)'(1);
  assign dot_w = {1'b0, dot_sum} + (SW+1)'(p_ab);
  assign sqa_w = {1'b0, square_sum_a} + (SW+1)'(p_aa);
  assign sqb_w = {1'b0, square_sum_b} + (SW+1)'(p_bb);

  // saturating accumulate, only when both ratings are present
  always_comb begin
    upd.count = pair_count;
    upd.dot   = dot_sum;
    upd.sq_a  = square_sum_a;
    upd.sq_b  = square_sum_b;
    if (both) begin
      upd.count = (cnt_w > {1'b0, ccs_pkg::COUNT_MAX}) ? ccs_pkg::COUNT_MAX : cnt_w[CW-1:0];
      upd.dot   = (dot_w > {1'b0, ccs_pkg::SUM_MAX}) ? ccs_pkg::SUM_MAX : dot_w[SW-1:0];
      upd.sq_a  = (sqa_w > {1'b0, ccs_pkg::SUM_MAX}) ? ccs_pkg::SUM_MAX : sqa_w[SW-1:0];
      upd.sq_b  = (sqb_w > {1'b0, ccs_pkg::SUM_MAX}) ? ccs_pkg::SUM_MAX : sqb_w[SW-1:0];
    end
  end

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && s_tlast;
  assign push_job = upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count   <= '0;
      dot_sum      <= '0;
      square_sum_a <= '0;
      square_sum_b <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        pair_count   <= '0;
        dot_sum      <= '0;
        square_sum_a <= '0;
        square_sum_b <= '0;
      end else begin
        pair_count   <= upd.count;
        dot_sum      <= upd.dot;
        square_sum_a <= upd.sq_a;
        square_sum_b <= upd.sq_b;
      end
    end
  end

endmodule

@@ sv/ccs_queue.sv @@
// Short job queue between front and back end.
// Depends on ccs_pkg.
`timescale 1ns / 1ps

module ccs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ccs_pkg::job_t push_job,
  input  logic          pop,
  output ccs_pkg::job_t pop_job,
  output logic          full,
  output logic          empty
);

  localparam int DEPTH = ccs_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ccs_pkg::job_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        fill <= fill + CNT_W'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/ccs_back.sv @@
// Back end: product of the square sums, integer root, Q1.15 divide, output register.
// Depends on ccs_pkg.
`timescale 1ns / 1ps

module ccs_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  output logic                           pop,
  input  ccs_pkg::job_t                  pop_job,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ccs_pkg::OUT_DATA_W-1:0] m_tdata   // similarity, corated_count, zero pad
);

  localparam int SW     = ccs_pkg::SUM_W;
  localparam int PW     = ccs_pkg::PROD_W;
  localparam int RTW    = ccs_pkg::ROOT_W;
  localparam int FW     = ccs_pkg::FRAC_W;
  localparam int LO_W   = (SW + 1) / 2;
  localparam int HI_W   = SW - LO_W;
  localparam int MW     = SW + LO_W;
  localparam int STEP_W = $clog2(RTW);
  localparam int PAD_W  = ccs_pkg::OUT_DATA_W - ccs_pkg::SIM_W - ccs_pkg::COUNT_W;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL_LO = 7'b0000010,
    ST_MUL_HI = 7'b0000100,
    ST_SQRT   = 7'b0001000,
    ST_DCHK   = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t        state;
  ccs_pkg::job_t job;
  logic [PW-1:0]   prod;
  logic [RTW-1:0]  root;
  logic [RTW:0]    sq_rem;
  logic [SW-1:0]   div_rem;
  logic [FW-1:0]   quo;
  logic [STEP_W-1:0] step;
  logic [ccs_pkg::SIM_W-1:0] sim;

  logic [LO_W-1:0] mul_b;
  logic [MW-1:0]   pp;
  logic [RTW+2:0]  rem_sh, trial, rem_sub;
  logic            sq_ge;
  logic [SW:0]     d_sh, d_sub;
  logic            d_ge;
  logic            trivial;
  logic            out_free;

  // one shared 21x11 multiplier, low half then high half
  assign mul_b = (state == ST_MUL_LO) ? job.sq_b[LO_W-1:0]
                                      : LO_W'(job.sq_b[SW-1:LO_W]);
  assign pp    = job.sq_a * mul_b;

  // restoring square root, two radicand bits a step
  assign rem_sh  = {sq_rem, prod[PW-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};
  assign sq_ge   = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  // restoring divide, one quotient bit a step; dividend < divisor here
  assign d_sh  = {div_rem, 1'b0};
  assign d_ge  = (d_sh >= {1'b0, root});
  assign d_sub = d_sh - {1'b0, root};

  assign trivial  = (pop_job.count <= ccs_pkg::COUNT_W'(1)) ||
                    (pop_job.sq_a == '0) || (pop_job.sq_b == '0);
  assign out_free = !m_tvalid || m_tready;
  assign pop      = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= trivial ? ST_DONE : ST_MUL_LO;
          end
        end
        ST_MUL_LO: state <= ST_MUL_HI;
        ST_MUL_HI: state <= ST_SQRT;
        ST_SQRT: begin
          if (step == '0) begin
            state <= ST_DCHK;
          end
        end
        ST_DCHK: state <= (job.dot >= root) ? ST_DONE : ST_DIV;
        ST_DIV: begin
          if (step == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        job <= pop_job;
        sim <= '0;
      end
      ST_MUL_LO: prod <= PW'(pp);
      ST_MUL_HI: begin
        prod   <= prod + {pp[SW+HI_W-1:0], {LO_W{1'b0}}};
        root   <= '0;
        sq_rem <= '0;
        step   <= STEP_W'(RTW - 1);
      end
      ST_SQRT: begin
        prod   <= {prod[PW-3:0], 2'b00};
        root   <= {root[RTW-2:0], sq_ge};
        sq_rem <= sq_ge ? rem_sub[RTW:0] : rem_sh[RTW:0];
        step   <= step - STEP_W'(1);
      end
      ST_DCHK: begin
        sim     <= ccs_pkg::Q_ONE;
        div_rem <= job.dot;
        quo     <= '0;
        step    <= STEP_W'(FW - 1);
      end
      ST_DIV: begin
        div_rem <= d_ge ? d_sub[SW-1:0] : d_sh[SW-1:0];
        quo     <= {quo[FW-2:0], d_ge};
        step    <= step - STEP_W'(1);
        if (step == '0) begin
          sim <= {1'b0, quo[FW-2:0], d_ge};
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= {{PAD_W{1'b0}}, job.count, sim};
        end
      end
      default: ;
    endcase
  end

endmodule

@@ sv/corated_cosine_similarity_unit.sv @@
// Co-rated cosine similarity unit: top level joining front end, job queue and back end.
// Depends on ccs_pkg, ccs_front, ccs_queue, ccs_back.
//
//  port group  dir  width  contents (low bit up)
//  s_*         in   8+1    tdata: rating_a, rating_b; tlast: last_user
//  m_*         out  32     tdata: similarity (Q1.15), corated_count, zero pad
//
// One rating transaction is taken per cycle while the job queue has room.
// Each vector pair then passes the back end in order: load, the split 21x11 product,
// square root, compare, divide, hand-over to the output register. The divide is
// skipped if the ratio clamps to one; with too few users only load and hand-over run.
// Two finished pairs may wait in the queue; input stalls only when it is full.
// rst is synchronous and clears the accumulators, queue and output valid.
`timescale 1ns / 1ps

module corated_cosine_similarity_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ccs_pkg::IN_DATA_W-1:0]  s_tdata,   // rating_a, rating_b
  input  logic                           s_tlast,   // last_user
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ccs_pkg::OUT_DATA_W-1:0] m_tdata    // similarity, corated_count, pad
);

  logic          push, pop, q_full, q_empty;
  ccs_pkg::job_t push_job, pop_job;

  ccs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  ccs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  ccs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .pop      (pop),
    .pop_job  (pop_job),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ sv/ccs_checker.sv @@
// Port-level checker for the co-rated cosine similarity unit, bound to the top level.
// Depends on ccs_pkg and corated_cosine_similarity_unit_assert.svh.
`timescale 1ns / 1ps
`include "corated_cosine_similarity_unit_assert.svh"

module ccs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ccs_pkg::OUT_DATA_W-1:0] m_tdata
);

  `CCS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `CCS_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  `CCS_ASSERT_NOW(a_sim_range, clk, rst, m_tvalid, m_tdata[15:0] <= ccs_pkg::Q_ONE)
  `CCS_ASSERT_NOW(a_few_pairs, clk, rst, m_tvalid && (m_tdata[29:16] <= 14'd1), m_tdata[15:0] == 16'd0)

endmodule

bind corated_cosine_similarity_unit ccs_checker u_ccs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
